// ----- rtl/core/itc_pkg.sv -----
// Shared types and constants of the interval tick counter bank.
package itc_pkg;

	localparam int unsigned STEP_PER_SLOT_MS = 10;
	localparam int unsigned PHASE_PERIOD_MS  = 3600;
	localparam int unsigned SLOT_COUNT       = 360;

	localparam int unsigned INTERVAL_W = 12;
	localparam int unsigned PHASE_W    = 12;
	localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
	localparam int unsigned REM_W      = $clog2(SLOT_COUNT + 1);
	localparam int unsigned SUBMS_W    = $clog2(STEP_PER_SLOT_MS + 1);
	localparam int unsigned COUNT_W    = 16;
	localparam int unsigned VALUE_W    = 32;

	// interval / STEP as (interval * RECIP_FACTOR) >> RECIP_SHIFT, low by at most one
	localparam int unsigned RECIP_SHIFT  = 16;
	localparam int unsigned RECIP_FACTOR = (1 << RECIP_SHIFT) / STEP_PER_SLOT_MS;
	localparam int unsigned PROD_W       = INTERVAL_W + RECIP_SHIFT + 1;
	localparam int unsigned MUL_W        = INTERVAL_W + 8;

	localparam logic [VALUE_W-1:0] TICK_LIMIT = 32'hFFFF_FBFF;
	localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_TICK   = 2'd0,
		OP_ATTACH = 2'd1,
		OP_DETACH = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic              slot_ok;
		logic [SLOT_W-1:0] slot;
	} cmd_t;

	typedef struct packed {
		logic [REM_W-1:0]   rem;
		logic [COUNT_W-1:0] subs;
		logic [VALUE_W-1:0] tick;
		logic [VALUE_W-1:0] roll;
	} entry_t;

	localparam int unsigned ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic push;
		logic full;
	} q_ctl_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_OP,
		BK_WALK
	} bk_state_t;

endpackage

// ----- rtl/core/itc_if.sv -----
// Word channels of the interval tick counter bank.
interface itc_req_if;
	import itc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [1:0]            operation;
	logic [INTERVAL_W-1:0] interval_ms;
	modport source(output valid, operation, interval_ms, input ready);
	modport sink(input valid, operation, interval_ms, output ready);
endinterface

interface itc_rsp_if;
	import itc_pkg::*;
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] tick_value;
	logic [VALUE_W-1:0] roll_value;
	logic [COUNT_W-1:0] subscriber_count;
	logic               error_flag;
	modport source(output valid, tick_value, roll_value, subscriber_count, error_flag,
		input ready);
	modport sink(input valid, tick_value, roll_value, subscriber_count, error_flag,
		output ready);
endinterface

// ----- rtl/core/itc_ram.sv -----
// Generic single write, single read RAM with registered read data.
module itc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule

// ----- rtl/core/itc_fifo.sv -----
// Two-entry command queue between the front and back ends.
module itc_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  itc_pkg::cmd_t  push_cmd,
	input  logic           pop,
	output itc_pkg::cmd_t  head,
	output logic           empty,
	output logic           full
);
	import itc_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head  = slot_q[rd_ptr_q];
	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- rtl/core/itc_front.sv -----
// Front end: accepts words and maps the interval onto a slot index.
module itc_front (
	input  logic           clk,
	input  logic           arst_n,
	itc_req_if.sink        req,
	input  logic           clear_done,
	output itc_pkg::q_ctl_t q_ctl_push,
	input  logic           q_full,
	output itc_pkg::cmd_t  push_cmd
);
	import itc_pkg::*;

	logic                  busy_s1;
	op_t                   op_s1;
	logic [INTERVAL_W-1:0] ival_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [INTERVAL_W-1:0] q_est;
	logic [MUL_W-1:0]      r_est;
	logic [INTERVAL_W-1:0] quot;
	logic [MUL_W-1:0]      rem;
	logic                  push;

	assign push       = busy_s1 && !q_full;
	assign req.ready  = clear_done && (!busy_s1 || !q_full);
	assign q_ctl_push = '{push: push, full: q_full};

	// quotient estimate is exact or one low; a single correction fixes it
	always_comb begin
		q_est = prod_s1[RECIP_SHIFT +: INTERVAL_W];
		r_est = MUL_W'(ival_s1) - MUL_W'(q_est) * MUL_W'(STEP_PER_SLOT_MS);
		if (r_est >= MUL_W'(STEP_PER_SLOT_MS)) begin
			quot = q_est + INTERVAL_W'(1);
			rem  = r_est - MUL_W'(STEP_PER_SLOT_MS);
		end else begin
			quot = q_est;
			rem  = r_est;
		end
		push_cmd.op      = op_s1;
		push_cmd.slot_ok = (ival_s1 != '0) && (rem == '0)
			&& (quot <= INTERVAL_W'(SLOT_COUNT));
		push_cmd.slot    = SLOT_W'(quot - INTERVAL_W'(1));
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1   <= op_t'(req.operation);
			ival_s1 <= req.interval_ms;
			prod_s1 <= PROD_W'(req.interval_ms) * PROD_W'(RECIP_FACTOR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			busy_s1 <= 1'b1;
		end else if (push) begin
			busy_s1 <= 1'b0;
		end
	end
endmodule

// ----- rtl/core/itc_back.sv -----
// Back end: slot memory, phase counter, slot walk and result register.
module itc_back (
	input  logic          clk,
	input  logic          arst_n,
	input  itc_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          clear_done,
	itc_rsp_if.source     rsp
);
	import itc_pkg::*;

	bk_state_t             state_q, state_n;
	logic [SLOT_W-1:0]     clr_cnt_q;
	logic [PHASE_W-1:0]    phase_q, phase_n;
	logic [SUBMS_W-1:0]    sub_ms_q, sub_ms_n;
	logic                  bound_n, wrap_n;
	logic                  fire_q, wrap_q;
	logic [REM_W-1:0]      walk_cnt_q;
	logic                  pend_q;
	logic [SLOT_W-1:0]     wb_slot_q;
	cmd_t                  cmd_q;
	logic                  out_free;
	logic                  load_out;
	logic                  rd_en, wr_en;
	logic [SLOT_W-1:0]     rd_addr, wr_addr;
	logic [ENTRY_W-1:0]    rd_raw, wr_data;
	entry_t                e_rd, e_op, e_walk;
	logic                  op_err;
	logic [VALUE_W-1:0]    out_tick_n, out_roll_n;
	logic [COUNT_W-1:0]    out_subs_n;
	logic                  out_err_n;
	logic                  out_valid_q;
	logic [VALUE_W-1:0]    out_tick_q, out_roll_q;
	logic [COUNT_W-1:0]    out_subs_q;
	logic                  out_err_q;

	itc_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign e_rd       = entry_t'(rd_raw);
	assign out_free   = !out_valid_q || rsp.ready;
	assign clear_done = (state_q != BK_CLEAR);

	// next phase for a tick word
	always_comb begin
		phase_n  = phase_q + PHASE_W'(1);
		sub_ms_n = sub_ms_q + SUBMS_W'(1);
		bound_n  = (sub_ms_n == SUBMS_W'(STEP_PER_SLOT_MS));
		if (bound_n) begin
			sub_ms_n = '0;
		end
		wrap_n = (phase_n >= PHASE_W'(PHASE_PERIOD_MS));
		if (wrap_n) begin
			phase_n  = '0;
			sub_ms_n = '0;
		end
	end

	// attach, detach or read on one entry
	always_comb begin
		e_op   = e_rd;
		op_err = 1'b0;
		case (cmd_q.op)
			OP_ATTACH: begin
				if (e_rd.subs == COUNT_MAX) begin
					op_err = 1'b1;
				end else begin
					e_op.subs = e_rd.subs + COUNT_W'(1);
				end
			end
			OP_DETACH: begin
				if (e_rd.subs == '0) begin
					op_err = 1'b1;
				end else begin
					e_op.subs = e_rd.subs - COUNT_W'(1);
					if (e_op.subs == '0) begin
						e_op.tick = '0;
					end
				end
			end
			default: ;
		endcase
	end

	// rem holds the slot-boundary count modulo the slot's period
	always_comb begin
		logic hit;
		e_walk = e_rd;
		hit    = 1'b0;
		if (fire_q) begin
			e_walk.rem = e_rd.rem + REM_W'(1);
			if (e_walk.rem == REM_W'(wb_slot_q) + REM_W'(1)) begin
				hit        = 1'b1;
				e_walk.rem = '0;
			end
		end
		if (wrap_q) begin
			e_walk.rem = '0;
		end
		if (hit && e_rd.subs != '0) begin
			e_walk.tick = e_rd.tick + VALUE_W'(1);
			if (e_walk.tick == TICK_LIMIT) begin
				e_walk.tick = '0;
				e_walk.roll = e_rd.roll + VALUE_W'(1);
			end
		end
	end

	always_comb begin
		state_n    = state_q;
		pop        = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		wr_en      = 1'b0;
		wr_addr    = '0;
		wr_data    = '0;
		load_out   = 1'b0;
		out_tick_n = '0;
		out_roll_n = '0;
		out_subs_n = '0;
		out_err_n  = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
				if (clr_cnt_q == SLOT_W'(SLOT_COUNT - 1)) begin
					state_n = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (!q_empty && out_free) begin
					pop = 1'b1;
					if (head.op == OP_TICK) begin
						load_out = 1'b1;
						if (bound_n || wrap_n) begin
							state_n = BK_WALK;
						end
					end else if (!head.slot_ok) begin
						load_out  = 1'b1;
						out_err_n = 1'b1;
					end else begin
						rd_en   = 1'b1;
						rd_addr = head.slot;
						state_n = BK_OP;
					end
				end
			end
			BK_OP: begin
				wr_en      = 1'b1;
				wr_addr    = cmd_q.slot;
				wr_data    = e_op;
				load_out   = 1'b1;
				out_tick_n = e_op.tick;
				out_roll_n = e_op.roll;
				out_subs_n = e_op.subs;
				out_err_n  = op_err;
				state_n    = BK_IDLE;
			end
			BK_WALK: begin
				rd_en   = (walk_cnt_q != REM_W'(SLOT_COUNT));
				rd_addr = walk_cnt_q[SLOT_W-1:0];
				if (pend_q) begin
					wr_en   = 1'b1;
					wr_addr = wb_slot_q;
					wr_data = e_walk;
				end
				if (walk_cnt_q == REM_W'(SLOT_COUNT)) begin
					state_n = BK_IDLE;
				end
			end
			default: state_n = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		wb_slot_q <= walk_cnt_q[SLOT_W-1:0];
		if (load_out) begin
			out_tick_q <= out_tick_n;
			out_roll_q <= out_roll_n;
			out_subs_q <= out_subs_n;
			out_err_q  <= out_err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			phase_q     <= '0;
			sub_ms_q    <= '0;
			fire_q      <= 1'b0;
			wrap_q      <= 1'b0;
			walk_cnt_q  <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (pop && head.op == OP_TICK) begin
				phase_q    <= phase_n;
				sub_ms_q   <= sub_ms_n;
				fire_q     <= bound_n;
				wrap_q     <= wrap_n;
				walk_cnt_q <= '0;
				pend_q     <= 1'b0;
			end else if (state_q == BK_WALK) begin
				pend_q <= rd_en;
				if (rd_en) begin
					walk_cnt_q <= walk_cnt_q + REM_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.tick_value       = out_tick_q;
	assign rsp.roll_value       = out_roll_q;
	assign rsp.subscriber_count = out_subs_q;
	assign rsp.error_flag       = out_err_q;
endmodule

// ----- rtl/core/interval_tick_counter_bank.sv -----
// Top level: bank of 360 interval timers with tick, attach, detach and read.
// Path: front register, command queue, then for attach/detach/read the slot RAM read
//   and the result register; a tick or an invalid interval goes straight to the result register.
// Words: the back end finishes each non-tick word before it pops the next; a tick on a 10 ms boundary
//   walks every slot through the single RAM read port.
// Reset: arst_n clears control; the slot RAM is then cleared one slot per cycle,
//   every slot in turn, while req.ready stays low.
module interval_tick_counter_bank (
	input  logic      clk,
	input  logic      arst_n,
	itc_req_if.sink   req,
	itc_rsp_if.source rsp
);
	import itc_pkg::*;

	// front end classifies words, back end owns all slot state
	q_ctl_t q_ctl;
	cmd_t   push_cmd;
	cmd_t   head;
	logic   q_full;
	logic   q_empty;
	logic   pop;
	logic   clear_done;

	itc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.clear_done (clear_done),
		.q_ctl_push (q_ctl),
		.q_full     (q_full),
		.push_cmd   (push_cmd)
	);

	// short queue so the front keeps taking words during a slot walk
	itc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_ctl.push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	itc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_empty    (q_empty),
		.pop        (pop),
		.clear_done (clear_done),
		.rsp        (rsp)
	);

	// no word is taken while the slot RAM is being cleared
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!clear_done |-> !req.ready)
		else $error("word accepted during RAM clear");

	// queue push only with room
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.push |-> !q_ctl.full)
		else $error("push into full queue");

	// back end pops only an occupied queue
	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from empty queue");
endmodule
